@@ hw/rtl/sample_histogram_engine_top_assert.svh @@
// assertion macros for the histogram engine checker
`ifndef SAMPLE_HISTOGRAM_ENGINE_TOP_ASSERT_SVH
`define SAMPLE_HISTOGRAM_ENGINE_TOP_ASSERT_SVH

// clocked check, off while reset is held
`define SHE_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds through reset
`define SHE_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/she_pkg.sv @@
`default_nettype none
package she_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_DATA_BITS = 5;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TWO_DIM   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYTE      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIN_BITS  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGNED    = 2'd3;

    localparam logic [4:0] BIN_BITS_RESET = 5'd8;
    localparam logic [4:0] WIDTH_BYTE     = 5'd8;
    localparam logic [4:0] WIDTH_WORD     = 5'd16;
    localparam logic [4:0] MAX_BITS_2D    = 5'd8;

    localparam logic [15:0] MASK_WORD = 16'hFFFF;
    localparam logic [15:0] MASK_BYTE = 16'h00FF;
    localparam logic [15:0] MASK_HIGH = 16'hFF00;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic wr_inc;
        logic clr_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } sts_t;

    // bin bits clamped to 1..sample width, and to 8 for joint pairs
    function automatic logic [4:0] eff_bits(input logic [4:0] req, input logic byte_mode,
                                            input logic two_dim);
        logic [4:0] w;
        logic [4:0] b;
        w = byte_mode ? WIDTH_BYTE : WIDTH_WORD;
        b = req;
        if (b == 5'd0) b = 5'd1;
        if (b > w) b = w;
        if (two_dim && (b > MAX_BITS_2D)) b = MAX_BITS_2D;
        return b;
    endfunction

    // keep the top b bits of the sample, flip the msb for signed data
    function automatic logic [15:0] axis_index(input logic [15:0] sample,
                                               input logic byte_mode,
                                               input logic [4:0] b,
                                               input logic sgn);
        logic [15:0] v;
        logic [4:0] sh;
        logic [15:0] idx;
        v = byte_mode ? ((sample & MASK_BYTE) & ~MASK_HIGH) : (sample & MASK_WORD);
        sh = (byte_mode ? WIDTH_BYTE : WIDTH_WORD) - b;
        idx = v >> sh;
        if (sgn) idx = idx ^ (16'd1 << (b - 5'd1));
        return idx;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/she_ram.sv @@
`default_nettype none
module she_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ hw/rtl/she_datapath.sv @@
`default_nettype none
module she_datapath #(
    parameter int INDEX_BITS = 16,
    parameter int COUNT_BITS = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [she_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [she_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  wire logic [1:0]                          s_action,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_sample_x,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_sample_y,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_bin_address,
    input  wire she_pkg::cmd_t                       cmd,
    output she_pkg::sts_t                            sts,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [COUNT_BITS-1:0]                    m_bin_count
);

    logic                  two_dim_reg;
    logic                  byte_reg;
    logic [4:0]            bin_bits_reg;
    logic                  signed_reg;

    logic [INDEX_BITS-1:0] addr_reg;
    logic [INDEX_BITS-1:0] addr_next;
    logic [INDEX_BITS-1:0] clr_cnt_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [COUNT_BITS-1:0] m_bin_count_reg;

    logic [4:0]            b;
    logic [15:0]           x_idx;
    logic [15:0]           y_idx;
    logic [15:0]           bin;

    logic                  ram_wr_en;
    logic [INDEX_BITS-1:0] ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;
    logic [COUNT_BITS-1:0] ram_rd_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            two_dim_reg  <= 1'b0;
            byte_reg     <= 1'b0;
            bin_bits_reg <= she_pkg::BIN_BITS_RESET;
            signed_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                she_pkg::CFG_TWO_DIM:  two_dim_reg  <= cfg_wr_data[0];
                she_pkg::CFG_BYTE:     byte_reg     <= cfg_wr_data[0];
                she_pkg::CFG_BIN_BITS: bin_bits_reg <= cfg_wr_data;
                she_pkg::CFG_SIGNED:   signed_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // bin index of the incoming word
    always_comb begin
        b     = she_pkg::eff_bits(bin_bits_reg, byte_reg, two_dim_reg);
        x_idx = she_pkg::axis_index(s_sample_x, byte_reg, b, signed_reg);
        y_idx = she_pkg::axis_index(s_sample_y, byte_reg, b, signed_reg);
        bin   = two_dim_reg ? ((x_idx << b) + y_idx) : x_idx;
        addr_next = addr_reg;
        if (cmd.accept) begin
            addr_next = (s_action == she_pkg::ACT_READ) ? s_bin_address[INDEX_BITS-1:0]
                                                        : bin[INDEX_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
    end

    // clearing pass counter, wraps back to zero after the last bin
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign ram_wr_en   = cmd.wr_inc | cmd.clr_step;
    assign ram_wr_addr = cmd.clr_step ? clr_cnt_reg : addr_reg;
    assign ram_wr_data = cmd.clr_step ? '0 : ram_rd_data + 1'b1;

    she_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (1 << INDEX_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_bin_count_reg <= ram_rd_data;
        end
    end

    assign sts.clr_last = &clr_cnt_reg;
    assign sts.out_busy = m_valid_reg & ~m_ready;
    assign m_valid      = m_valid_reg;
    assign m_bin_count  = m_bin_count_reg;

endmodule
`default_nettype wire

@@ hw/rtl/she_ctrl.sv @@
`default_nettype none
module she_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [1:0]     s_action,
    input  wire she_pkg::sts_t  sts,
    output she_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_RD_RD,
        ST_RD_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_action)
                        she_pkg::ACT_ADD:   state_next = ST_ADD_RD;
                        she_pkg::ACT_READ:  state_next = ST_RD_RD;
                        she_pkg::ACT_CLEAR: state_next = ST_CLEAR;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR: state_next = ST_IDLE;
            ST_RD_RD:  state_next = ST_RD_OUT;
            ST_RD_OUT: begin
                // read data holds in the ram until the output register frees up
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.accept   = (state_reg == ST_IDLE) & s_valid;
    assign cmd.rd_en    = (state_reg == ST_ADD_RD) | (state_reg == ST_RD_RD);
    assign cmd.wr_inc   = (state_reg == ST_ADD_WR);
    assign cmd.clr_step = (state_reg == ST_CLEAR);
    assign cmd.load_out = (state_reg == ST_RD_OUT) & ~sts.out_busy;

endmodule
`default_nettype wire

@@ hw/rtl/sample_histogram_engine_top.sv @@
// add: a read then a write of one bin in the store with registered read, then the next word
// read: bin_count through the address, store read and output registers, loaded once the output
// register is free; next word taken in the cycle after bin_count is loaded
// clear: one bin zeroed per cycle through the store write port, s_ready low throughout
// reset: control and config registers return to defaults, then a clearing pass
// zeroes the store with s_ready low; config writes are taken throughout the pass
`default_nettype none
module sample_histogram_engine_top #(
    parameter int INDEX_BITS = 16,
    parameter int COUNT_BITS = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [she_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [she_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_action,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_sample_x,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_sample_y,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_bin_address,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [COUNT_BITS-1:0]                    m_bin_count
);

    she_pkg::cmd_t cmd;
    she_pkg::sts_t sts;

    she_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .sts      (sts),
        .cmd      (cmd)
    );

    she_datapath #(
        .INDEX_BITS (INDEX_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_action      (s_action),
        .s_sample_x    (s_sample_x),
        .s_sample_y    (s_sample_y),
        .s_bin_address (s_bin_address),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bin_count   (m_bin_count)
    );

endmodule
`default_nettype wire

@@ hw/rtl/she_checker.sv @@
`default_nettype none
`include "sample_histogram_engine_top_assert.svh"
module she_checker #(
    parameter int COUNT_BITS = 64
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic [1:0]            s_action,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [COUNT_BITS-1:0] m_bin_count
);

    logic s_take;
    logic busy_take;
    logic add_take;
    logic out_stall;

    assign s_take    = s_valid && s_ready;
    assign busy_take = s_take && (s_action == she_pkg::ACT_ADD || s_action == she_pkg::ACT_READ
                                  || s_action == she_pkg::ACT_CLEAR);
    assign add_take  = s_take && (s_action == she_pkg::ACT_ADD);
    assign out_stall = m_valid && !m_ready;

    // reset starts the clearing pass and drops any pending result
    `SHE_ASSERT(a_rst_busy, aclk, !aresetn |=> !s_ready && !m_valid, "not busy after reset")

    // a stalled result holds its word
    `SHE_ASSERT_RST(a_hold_valid, aclk, aresetn, out_stall |=> m_valid, "valid dropped")
    `SHE_ASSERT_RST(a_hold_data, aclk, aresetn, out_stall |=> $stable(m_bin_count), "word changed")

    // add, read and clear each leave the engine busy for the next cycle
    `SHE_ASSERT_RST(a_busy_after, aclk, aresetn, busy_take |=> !s_ready, "ready after a word")

    // an add returns the engine to ready once its read-modify-write is done
    `SHE_ASSERT_RST(a_add_done, aclk, aresetn, add_take |=> ##2 s_ready, "add too slow")

endmodule

bind sample_histogram_engine_top she_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_she_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_action    (s_action),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bin_count (m_bin_count)
);
`default_nettype wire

@@ tb/hist_bin_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module hist_bin_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [she_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [she_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic [1:0]                          s_action,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_sample_x,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_sample_y,
    input  wire logic [she_pkg::SAMPLE_BITS-1:0]     s_bin_address,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [63:0]                         m_bin_count,
    output int unsigned                              fail_count,
    output int unsigned                              counts_owed,
    output int unsigned                              reads_checked
);

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the block's configuration registers
    logic        two_dim_q;
    logic        byte_q;
    logic [4:0]  bits_q;
    logic        signed_q;

    // bins that were never counted since the last clear read as zero
    logic [63:0] bin_tally [int unsigned];
    logic [63:0] expected_counts [$];
    int unsigned mismatches;
    int unsigned reads_seen;

    // top b bits of a w-bit sample, msb flipped for signed data
    function automatic int unsigned axis_bin(input logic [15:0] sample, input int w,
                                             input int b);
        int unsigned v;
        v = (w == 8) ? int'(sample & she_pkg::MASK_BYTE) : int'(sample);
        v = v >> (w - b);
        if (signed_q) v = v ^ (1 << (b - 1));
        return v;
    endfunction

    always @(posedge aclk) begin
        int w;
        int b;
        int unsigned bin;
        logic [63:0] want;
        if (!aresetn) begin
            two_dim_q = 1'b0;
            byte_q    = 1'b0;
            bits_q    = she_pkg::BIN_BITS_RESET;
            signed_q  = 1'b0;
            bin_tally.delete();
            expected_counts.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    she_pkg::CFG_TWO_DIM:  two_dim_q = cfg_wr_data[0];
                    she_pkg::CFG_BYTE:     byte_q    = cfg_wr_data[0];
                    she_pkg::CFG_BIN_BITS: bits_q    = cfg_wr_data[4:0];
                    she_pkg::CFG_SIGNED:   signed_q  = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_action)
                    she_pkg::ACT_ADD: begin
                        w = byte_q ? 8 : 16;
                        b = int'(bits_q);
                        if (b < 1) b = 1;
                        if (b > w) b = w;
                        if (two_dim_q && b > 8) b = 8;
                        bin = axis_bin(s_sample_x, w, b);
                        if (two_dim_q) bin = (bin << b) + axis_bin(s_sample_y, w, b);
                        bin = bin & 32'hFFFF;
                        if (bin_tally.exists(bin)) bin_tally[bin] = bin_tally[bin] + 64'd1;
                        else bin_tally[bin] = 64'd1;
                    end
                    she_pkg::ACT_READ: begin
                        bin = int'(s_bin_address);
                        expected_counts.push_back(bin_tally.exists(bin) ? bin_tally[bin] : 64'd0);
                    end
                    she_pkg::ACT_CLEAR: bin_tally.delete();
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                reads_seen++;
                if (expected_counts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("bin count %h arrived with no read outstanding", m_bin_count);
                end else begin
                    want = expected_counts.pop_front();
                    if (m_bin_count !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("read %0d: bin count expected %h, got %h",
                                     reads_seen, want, m_bin_count);
                    end
                end
            end
        end
        fail_count    <= mismatches;
        counts_owed   <= expected_counts.size();
        reads_checked <= reads_seen;
    end
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int PHASE_COUNT  = 9;
    localparam int PHASE_WORDS  = 148;
    localparam int DRAIN_CYCLES = 8;
    localparam int CLEAR_CYCLES = 65545;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic        two_d;
        logic        byte_mode;
        logic [4:0]  bits;
        logic        sgn;
        int          span;
    } bin_layout_t;

    // span is the number of bins the layout can reach, used to aim reads
    bin_layout_t bin_layouts [PHASE_COUNT] = '{
        '{1'b0, 1'b0, 5'd4,  1'b0, 16},
        '{1'b1, 1'b1, 5'd2,  1'b1, 16},
        '{1'b0, 1'b1, 5'd31, 1'b1, 256},
        '{1'b1, 1'b0, 5'd16, 1'b0, 65536},
        '{1'b0, 1'b0, 5'd0,  1'b1, 2},
        '{1'b1, 1'b0, 5'd3,  1'b1, 64},
        '{1'b0, 1'b0, 5'd16, 1'b1, 65536},
        '{1'b1, 1'b1, 5'd1,  1'b0, 4},
        '{1'b0, 1'b1, 5'd5,  1'b0, 32}
    };

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [she_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
    logic [she_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data;
    logic                                s_valid;
    logic                                s_ready;
    logic [1:0]                          s_action;
    logic [she_pkg::SAMPLE_BITS-1:0]     s_sample_x;
    logic [she_pkg::SAMPLE_BITS-1:0]     s_sample_y;
    logic [she_pkg::SAMPLE_BITS-1:0]     s_bin_address;
    logic                                m_valid;
    logic                                m_ready;
    logic [63:0]                         m_bin_count;

    int unsigned fail_count;
    int unsigned counts_owed;
    int unsigned reads_checked;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned adds_sent;
    int unsigned clears_sent;
    int unsigned cycle_count;
    logic        last_was_clear;

    sample_histogram_engine_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_sample_x    (s_sample_x),
        .s_sample_y    (s_sample_y),
        .s_bin_address (s_bin_address),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bin_count   (m_bin_count)
    );

    hist_bin_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_sample_x    (s_sample_x),
        .s_sample_y    (s_sample_y),
        .s_bin_address (s_bin_address),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bin_count   (m_bin_count),
        .fail_count    (fail_count),
        .counts_owed   (counts_owed),
        .reads_checked (reads_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bin counts outstanding",
                     cycle_count, counts_owed);
            $display("** sample_histogram_engine_top: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // valid is only lowered while idling, so a back-to-back word keeps it high
    task automatic send_word(input logic [1:0] act, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_sample_x    <= x;
        s_sample_y    <= y;
        s_bin_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_was_clear = (act == she_pkg::ACT_CLEAR);
        if (act == she_pkg::ACT_ADD) adds_sent++;
        if (act == she_pkg::ACT_CLEAR) clears_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (counts_owed != 0) @(posedge aclk);
    endtask

    // adds leave no result behind, and a clear keeps the store busy much longer
    task automatic settle();
        drain_results();
        repeat (last_was_clear ? CLEAR_CYCLES : DRAIN_CYCLES) @(posedge aclk);
    endtask

    // upper data bits of the one-bit registers carry noise
    task automatic program_layout(input bin_layout_t l);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= she_pkg::CFG_TWO_DIM;
        cfg_wr_data <= {4'($urandom_range(0, 15)), l.two_d};
        @(posedge aclk);
        cfg_index   <= she_pkg::CFG_BYTE;
        cfg_wr_data <= {4'($urandom_range(0, 15)), l.byte_mode};
        @(posedge aclk);
        cfg_index   <= she_pkg::CFG_BIN_BITS;
        cfg_wr_data <= l.bits;
        @(posedge aclk);
        cfg_index   <= she_pkg::CFG_SIGNED;
        cfg_wr_data <= {4'($urandom_range(0, 15)), l.sgn};
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int words;
        int prev_words;
        int pick;
        logic [15:0] addr;

        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= she_pkg::CFG_TWO_DIM;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_action      <= she_pkg::ACT_ADD;
        s_sample_x    <= '0;
        s_sample_y    <= '0;
        s_bin_address <= '0;
        send_idle_pct  = 37;
        recv_idle_pct  = 66;
        adds_sent      = 0;
        clears_sent    = 0;
        last_was_clear = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset layout: one axis, 16-bit samples, 8 bin bits, unsigned
        send_word(she_pkg::ACT_ADD,   16'h0000, 16'hFFFF, 16'hFFFF);
        send_word(she_pkg::ACT_ADD,   16'hFFFF, 16'h0000, 16'h0000);
        send_word(she_pkg::ACT_ADD,   16'h8000, 16'h5555, 16'hAAAA);
        send_word(she_pkg::ACT_ADD,   16'h7FFF, 16'hAAAA, 16'h5555);
        send_word(she_pkg::ACT_ADD,   16'h00FF, 16'hFFFF, 16'hFFFF);
        send_word(she_pkg::ACT_ADD,   16'hFF00, 16'h0000, 16'h0000);
        send_word(ACT_NOP,            16'hFFFF, 16'hFFFF, 16'h0000);
        send_word(she_pkg::ACT_READ,  16'hFFFF, 16'hFFFF, 16'h0000);
        send_word(she_pkg::ACT_READ,  16'h0000, 16'h0000, 16'h00FF);
        send_word(she_pkg::ACT_READ,  16'h5555, 16'hAAAA, 16'h0080);
        send_word(she_pkg::ACT_READ,  16'hAAAA, 16'h5555, 16'h007F);
        send_word(she_pkg::ACT_READ,  16'h0000, 16'h0000, 16'hFFFF);
        send_word(she_pkg::ACT_READ,  16'h0000, 16'h0000, 16'h0001);
        send_word(she_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(she_pkg::ACT_READ,  16'h0000, 16'h0000, 16'h0000);
        send_word(she_pkg::ACT_READ,  16'h0000, 16'h0000, 16'h00FF);
        send_word(she_pkg::ACT_ADD,   16'hFFFF, 16'h0000, 16'h0000);
        send_word(she_pkg::ACT_ADD,   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(she_pkg::ACT_ADD,   16'h0001, 16'h1234, 16'h8000);
        send_word(she_pkg::ACT_READ,  16'h0000, 16'h0000, 16'h00FF);
        send_word(she_pkg::ACT_READ,  16'h0000, 16'h0000, 16'h0000);
        send_word(she_pkg::ACT_READ,  16'hFFFF, 16'hFFFF, 16'h8000);
        settle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p < 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 66;
            end else if (p < 6) begin
                send_idle_pct = 66;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_layout(bin_layouts[p]);
            words = 0;
            while (words < PHASE_WORDS) begin
                prev_words = words;
                pick = $urandom_range(0, 99);
                addr = ($urandom_range(0, 3) != 0) ?
                       16'($urandom_range(0, bin_layouts[p].span - 1)) : 16'($urandom);
                if (p % 3 == 1 && words == PHASE_WORDS / 3) begin
                    send_word(she_pkg::ACT_CLEAR, pick_sample(), pick_sample(), addr);
                    words++;
                end else if (pick < 4) begin
                    // unused action, ignored by the block
                    send_word(ACT_NOP, pick_sample(), pick_sample(), addr);
                end else if (pick < 66) begin
                    send_word(she_pkg::ACT_ADD, pick_sample(), pick_sample(), addr);
                    words++;
                end else begin
                    send_word(she_pkg::ACT_READ, pick_sample(), pick_sample(), addr);
                    words++;
                end
                if (words != prev_words && words == PHASE_WORDS / 2) drain_results();
            end
            settle();
        end

        $display("covered %0d sample adds, %0d bin reads checked, %0d clears",
                 adds_sent, reads_checked, clears_sent);
        $display("over %0d bin layouts, 1d and 2d, byte and word samples, signed and unsigned",
                 PHASE_COUNT + 1);
        if (counts_owed != 0)
            $display("%0d bin counts never arrived", counts_owed);
        if (fail_count == 0 && counts_owed == 0) begin
            $display("** sample_histogram_engine_top: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** sample_histogram_engine_top: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
